// File: rtl/core/rdbs_pkg.sv
// Shared types and constants for the dead-block/stream replacement core.
// Holds the item structs, controller command and status structs, and codes.
// No dependencies.
package rdbs_pkg;

  localparam int SIDX_W = 11;
  localparam int ADDR_W = 48;
  localparam int MASK_W = 16;
  localparam int WAYF_W = 4;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] CNT_MAX = 2'd3;
  localparam logic [1:0] CNT_MIN = 2'd0;
  localparam logic [1:0] REUSE_RESET = 2'd1;
  localparam logic [1:0] REUSE_HIGH = 2'd2;
  localparam logic [1:0] STREAM_MIN = 2'd2;

  localparam logic [ADDR_W-1:0] STRIDE_ONE = 48'd64;
  localparam logic [ADDR_W-1:0] STRIDE_TWO = 48'd128;

  localparam logic [31:0] DECAY_RESET = 32'd100000;
  localparam logic [1:0] REG_SWEEP_INTERVAL = 2'd0;

  typedef struct packed {
    logic opcode;
    logic [SIDX_W-1:0] set_index;
    logic [WAYF_W-1:0] way;
    logic [MASK_W-1:0] valid_mask;
    logic [ADDR_W-1:0] address;
    logic hit;
  } req_t;

  typedef struct packed {
    logic [WAYF_W-1:0] victim_way;
    logic set_streaming;
    logic [1:0] inserted_rrpv;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic clear_wr;
    logic sweep_wr;
    logic row_sel;
    logic row_inc;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_update;
    logic sweep_due;
    logic row_last;
  } stat_t;

endpackage

// File: rtl/core/rdbs_ctrl.sv
// Controller state machine for the replacement core.
// Sequences clearing, item handling and decay sweeps; uses rdbs_pkg.
module rdbs_ctrl
  import rdbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_SWRD  = 6'b010000,
    S_SWWR  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_stall = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.row_sel = 1'b1;
        cmd.row_inc = 1'b1;
        if (stat.row_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec = 1'b1;
          state_next = (stat.is_update && stat.sweep_due) ? S_SWRD : S_IDLE;
        end
      end
      S_SWRD: begin
        cmd.row_sel = 1'b1;
        state_next = S_SWWR;
      end
      S_SWWR: begin
        cmd.row_sel = 1'b1;
        cmd.sweep_wr = 1'b1;
        cmd.row_inc = 1'b1;
        state_next = stat.row_last ? S_IDLE : S_SWRD;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// File: rtl/core/rdbs_datapath.sv
// Datapath of the replacement core: metadata memories, victim and update
// logic, update counter and result register; uses rdbs_pkg.
module rdbs_datapath
  import rdbs_pkg::*;
#(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic [31:0] sweep_interval,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int RSH = SIDX_W + SET_W;
  localparam longint RECIP = ((64'd1 << RSH) + NUM_SETS - 1) / NUM_SETS;
  localparam int RC_W = RSH + 1;
  localparam int PR_W = SIDX_W + RC_W;
  localparam int SN_W = SIDX_W + 17;
  localparam int SR_W = (SET_W > SIDX_W) ? SET_W : SIDX_W;
  localparam int ROW_W = 2 * NUM_WAYS;

  req_t req_q;
  logic [SIDX_W-1:0] quot;
  logic [PR_W-1:0] prod;
  logic [SN_W-1:0] qn;
  logic [SN_W-1:0] set_diff;
  logic [SET_W-1:0] set_rem;
  logic [SET_W-1:0] row;
  logic [SET_W-1:0] maddr;
  logic [WAY_W-1:0] way_tab [16];
  logic [WAY_W-1:0] way_m;

  logic [ROW_W-1:0] rrpv_mem [NUM_SETS];
  logic [ROW_W-1:0] reuse_mem [NUM_SETS];
  logic [ADDR_W-1:0] prev_mem [NUM_SETS];
  logic [1:0] score_mem [NUM_SETS];
  logic [ROW_W-1:0] rrpv_rd, reuse_rd, rrpv_wd, reuse_wd;
  logic [ADDR_W-1:0] prev_rd, prev_wd;
  logic [1:0] score_rd, score_wd;
  logic rrpv_we, upd_we, reuse_we;

  logic [31:0] upd_cnt;
  logic [32:0] cnt_inc;
  logic [31:0] period;

  logic inv_found, has3, has2, has1;
  logic [WAY_W-1:0] inv_way, top_way, vic_way;
  logic [1:0] top, age_add;
  logic [ROW_W-1:0] aged_row, upd_rrpv_row, upd_reuse_row, swept_row;
  logic addr_gt, near_stride, streaming;
  logic [ADDR_W-1:0] delta;
  logic [1:0] score_new, rc_old, rc_new, ins;
  rsp_t result;

  for (genvar g = 0; g < 16; g++) begin : g_waytab
    localparam int WR = g % NUM_WAYS;
    assign way_tab[g] = WR[WAY_W-1:0];
  end

  assign prod = PR_W'(req.set_index) * PR_W'(RECIP);
  assign qn = SN_W'(quot) * SN_W'(NUM_SETS);
  assign set_diff = SN_W'(req_q.set_index) - qn;
  assign set_rem = SET_W'(set_diff[SR_W-1:0]);
  assign way_m = way_tab[req_q.way];
  assign maddr = cmd.row_sel ? row : set_rem;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
      quot <= prod[RSH +: SIDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (cmd.row_inc) begin
      row <= stat.row_last ? '0 : row + SET_W'(1);
    end
  end
  assign stat.row_last = (row == SET_W'(NUM_SETS - 1));

  assign rrpv_we = cmd.clear_wr || cmd.exec;
  assign upd_we = cmd.clear_wr || (cmd.exec && stat.is_update);
  assign reuse_we = upd_we || cmd.sweep_wr;

  always_ff @(posedge clk) begin
    if (rrpv_we) rrpv_mem[maddr] <= rrpv_wd;
    rrpv_rd <= rrpv_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (reuse_we) reuse_mem[maddr] <= reuse_wd;
    reuse_rd <= reuse_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (upd_we) prev_mem[maddr] <= prev_wd;
    prev_rd <= prev_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (upd_we) score_mem[maddr] <= score_wd;
    score_rd <= score_mem[maddr];
  end

  always_comb begin
    inv_found = 1'b0;
    inv_way = '0;
    has3 = 1'b0;
    has2 = 1'b0;
    has1 = 1'b0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (w < MASK_W && !req_q.valid_mask[w[3:0]]) begin
        inv_found = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      has3 = has3 | (rrpv_rd[2*w +: 2] == 2'd3);
      has2 = has2 | (rrpv_rd[2*w +: 2] == 2'd2);
      has1 = has1 | (rrpv_rd[2*w +: 2] == 2'd1);
    end
    top = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
    age_add = RRPV_DISTANT - top;
    top_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rrpv_rd[2*w +: 2] == top) top_way = WAY_W'(w);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[2*w +: 2] = inv_found ? rrpv_rd[2*w +: 2] : rrpv_rd[2*w +: 2] + age_add;
      swept_row[2*w +: 2] = (reuse_rd[2*w +: 2] == CNT_MIN) ? CNT_MIN
                            : reuse_rd[2*w +: 2] - 2'd1;
    end
    vic_way = inv_found ? inv_way : top_way;
  end

  always_comb begin
    addr_gt = req_q.address > prev_rd;
    delta = addr_gt ? req_q.address - prev_rd : prev_rd - req_q.address;
    near_stride = (delta == STRIDE_ONE) || (delta == STRIDE_TWO);
    if (prev_rd == '0) begin
      score_new = CNT_MIN;
    end else if (near_stride) begin
      score_new = (score_rd == CNT_MAX) ? CNT_MAX : score_rd + 2'd1;
    end else begin
      score_new = (score_rd == CNT_MIN) ? CNT_MIN : score_rd - 2'd1;
    end
    streaming = stat.is_update ? (score_new >= STREAM_MIN) : (score_rd >= STREAM_MIN);
    rc_old = reuse_rd[2*way_m +: 2];
    if (req_q.hit) begin
      rc_new = (rc_old == CNT_MAX) ? CNT_MAX : rc_old + 2'd1;
    end else begin
      rc_new = (rc_old == CNT_MIN) ? CNT_MIN : rc_old - 2'd1;
    end
    if (streaming) ins = RRPV_DISTANT;
    else ins = (rc_new >= REUSE_HIGH) ? RRPV_NEAR : RRPV_LONG;
    upd_rrpv_row = rrpv_rd;
    upd_rrpv_row[2*way_m +: 2] = ins;
    upd_reuse_row = reuse_rd;
    upd_reuse_row[2*way_m +: 2] = rc_new;
  end

  always_comb begin
    if (cmd.clear_wr) begin
      rrpv_wd = {NUM_WAYS{RRPV_DISTANT}};
      reuse_wd = {NUM_WAYS{REUSE_RESET}};
      prev_wd = '0;
      score_wd = CNT_MIN;
    end else begin
      rrpv_wd = stat.is_update ? upd_rrpv_row : aged_row;
      reuse_wd = cmd.sweep_wr ? swept_row : upd_reuse_row;
      prev_wd = req_q.address;
      score_wd = score_new;
    end
  end

  assign stat.is_update = (req_q.opcode == OP_UPDATE);
  assign period = (sweep_interval == '0) ? 32'd1 : sweep_interval;
  assign cnt_inc = {1'b0, upd_cnt} + 33'd1;
  assign stat.sweep_due = (cnt_inc >= {1'b0, period});

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_cnt <= '0;
    end else if (cmd.exec && stat.is_update) begin
      upd_cnt <= stat.sweep_due ? '0 : cnt_inc[31:0];
    end
  end

  always_comb begin
    result.victim_way = stat.is_update ? '0 : WAYF_W'(vic_way);
    result.set_streaming = streaming;
    result.inserted_rrpv = stat.is_update ? ins : RRPV_NEAR;
  end

  assign stat.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) rsp <= result;
  end

`ifndef NO_ASSERTIONS
  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> stat.out_free) else $error("result register overwritten");
  a_cnt_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && stat.is_update && stat.sweep_due |=> upd_cnt == '0)
    else $error("update counter did not wrap");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !cmd.sweep_wr && !cmd.clear_wr && !cmd.row_sel)
    else $error("item write during row pass");
`endif

endmodule

// File: rtl/core/rrip_dead_block_stream_replacement_core.sv
// An item is captured in S_IDLE, read in S_ADDR and registered in S_EXEC once out_free.
// A new item is taken only in S_IDLE, after the per-set read-modify-write of the last.
// An update that ends a decay period adds a sweep of all NUM_SETS sets before the next item.
// Reset: synchronous; a clearing pass over all NUM_SETS sets follows, with input stalled.
// Top level of the replacement core: configuration register and APB port.
// Instantiates rdbs_ctrl and rdbs_datapath; uses rdbs_pkg.
module rrip_dead_block_stream_replacement_core
  import rdbs_pkg::*;
#(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] sweep_interval;
  cmd_t cmd;
  stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_interval <= DECAY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      sweep_interval <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr)
      REG_SWEEP_INTERVAL: prdata = sweep_interval;
      default: prdata = sweep_interval;
    endcase
  end

  rdbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rdbs_datapath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .sweep_interval (sweep_interval),
    .cmd            (cmd),
    .stat           (stat),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp)
  );

endmodule
